/* rtl/core/lfuc_pkg.sv */
package lfuc_pkg;

   // Field widths fixed by the request and result formats
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CFG_W = 5;

   // Capacity register value after reset
   localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

   // Request kinds
   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   // Control from the sequencer to the search unit
   typedef struct packed {
      logic clear;
      logic step;
   } srch_ctrl_type;

endpackage

/* rtl/core/lfu_cache_with_lru_tiebreak.sv */
// Channel   Ports                                 Handshake
// request   start, busy, req_action/key/value     taken when start & !busy
// result    rsp_valid, rsp_hit/read_value/...     one-cycle strobe, cannot stall
// config    csr_valid, csr_ready, csr_data        written when csr_valid & csr_ready
//
// Entries live in one memory with a registered read port; one entry is read per cycle.
// An item takes a search pass over the N entries in use and a decision step, followed,
// when an entry changes, by a read-modify-write pass over the same entries.
// Valid entries always occupy the lowest indices, so a fill count marks them and
// reset needs no clearing pass. Reset is synchronous and active high.
// The result strobe fires once per item; the receiver cannot stall it.
module lfu_cache_with_lru_tiebreak import lfuc_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_action,
   input  logic [KEY_W-1:0] req_key,
   input  logic [VAL_W-1:0] req_value,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic [VAL_W-1:0] rsp_read_value,
   output logic             rsp_evicted,
   output logic [KEY_W-1:0] rsp_evicted_key,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OW = $clog2(CAPACITY + 1);
   localparam int CW = (OW > CFG_W) ? OW : CFG_W;

   typedef struct packed {
      logic [KEY_W-1:0]       key;
      logic [VAL_W-1:0]       value;
      logic [COUNT_WIDTH-1:0] count;
      logic [IW-1:0]          rank;
   } word_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   word_type         mem [CAPACITY];
   word_type         rd_word_ff;
   logic [IW-1:0]    rd_addr;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   word_type         wr_word;
   word_type         upd_word;
   word_type         new_word;

   state_type        state_ff, state_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [OW-1:0]    occ_ff, occ_in;
   logic [OW-1:0]    end_ff;
   logic [CFG_W-1:0] cap_ff;
   logic             act_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;
   logic             bump_ff, ins_ff, evict_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff;
   logic [VAL_W-1:0] rsp_read_value_ff;
   logic             rsp_evicted_ff;
   logic [KEY_W-1:0] rsp_evicted_key_ff;

   srch_ctrl_type    ctrl;
   logic             found;
   logic [IW-1:0]    match_idx, match_rank, victim_idx, victim_rank;
   logic [VAL_W-1:0] match_value;
   logic [KEY_W-1:0] victim_key;

   logic [CW-1:0]    cap_eff;
   logic             cap_zero;
   logic             bump_w, ins_w, evict_w;
   logic             last;
   logic             accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Clamp the capacity register to the storage size
   assign cap_eff  = (CW'(cap_ff) > CW'(CAPACITY)) ? CW'(CAPACITY) : CW'(cap_ff);
   assign cap_zero = (cap_eff == '0);

   // Decide what the item does once the search pass has finished
   assign bump_w  = found && ((act_ff == ACT_GET) || !cap_zero);
   assign ins_w   = (act_ff == ACT_PUT) && !found && !cap_zero;
   assign evict_w = ins_w && (CW'(occ_ff) >= cap_eff);

   assign last = ((OW'(idx_ff) + OW'(1)) == end_ff);

   // Search unit: key match and victim choice
   lfuc_search #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .IDX_W       (IW)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .find_key    (key_ff),
      .entry_idx   (idx_ff),
      .entry_key   (rd_word_ff.key),
      .entry_value (rd_word_ff.value),
      .entry_count (rd_word_ff.count),
      .entry_rank  (rd_word_ff.rank),
      .found       (found),
      .match_idx   (match_idx),
      .match_rank  (match_rank),
      .match_value (match_value),
      .victim_idx  (victim_idx),
      .victim_rank (victim_rank),
      .victim_key  (victim_key)
   );

   // Fresh entry for an inserted key
   always_comb begin
      new_word.key   = key_ff;
      new_word.value = val_ff;
      new_word.count = COUNT_WIDTH'(1);
      new_word.rank  = '0;
   end

   // Rewrite one entry during the update pass
   always_comb begin
      upd_word = rd_word_ff;
      if (bump_ff) begin
         if (idx_ff == match_idx) begin
            if (rd_word_ff.count != '1) begin
               upd_word.count = rd_word_ff.count + COUNT_WIDTH'(1);
            end
            upd_word.rank = '0;
            if (act_ff == ACT_PUT) begin
               upd_word.value = val_ff;
            end
         end else if (rd_word_ff.rank < match_rank) begin
            upd_word.rank = rd_word_ff.rank + IW'(1);
         end
      end else if (ins_ff) begin
         if (evict_ff && (idx_ff == victim_idx)) begin
            upd_word = new_word;
         end else if (!(evict_ff && (rd_word_ff.rank > victim_rank))) begin
            upd_word.rank = rd_word_ff.rank + IW'(1);
         end
      end
   end

   // Sequence the search pass, the decision and the update pass
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      occ_in       = occ_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_word      = upd_word;
      ctrl         = '0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.clear = 1'b1;
               idx_in     = '0;
               state_in   = (occ_ff == '0) ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctrl.step = 1'b1;
            rd_addr   = idx_ff + IW'(1);
            if (last) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            idx_in       = '0;
            if (ins_w && !evict_w) begin
               wr_en   = 1'b1;
               wr_addr = occ_ff[IW-1:0];
               wr_word = new_word;
               occ_in  = occ_ff + OW'(1);
            end
            if ((bump_w || ins_w) && (occ_ff != '0)) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            wr_en   = 1'b1;
            rd_addr = idx_ff + IW'(1);
            if (last) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      rd_word_ff <= mem[rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   // Hold the item, the pass index and the decision
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         act_ff <= req_action;
         key_ff <= req_key;
         val_ff <= req_value;
         end_ff <= occ_ff;
      end
      if (state_ff == ST_DECIDE) begin
         bump_ff            <= bump_w;
         ins_ff             <= ins_w;
         evict_ff           <= evict_w;
         rsp_hit_ff         <= found;
         rsp_read_value_ff  <= ((act_ff == ACT_GET) && found) ? match_value : '0;
         rsp_evicted_ff     <= evict_w;
         rsp_evicted_key_ff <= evict_w ? victim_key : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

/* rtl/core/lfuc_search.sv */
module lfuc_search import lfuc_pkg::*; #(
   parameter int COUNT_WIDTH = 16,
   parameter int IDX_W       = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srch_ctrl_type          ctrl,
   input  logic [KEY_W-1:0]       find_key,
   input  logic [IDX_W-1:0]       entry_idx,
   input  logic [KEY_W-1:0]       entry_key,
   input  logic [VAL_W-1:0]       entry_value,
   input  logic [COUNT_WIDTH-1:0] entry_count,
   input  logic [IDX_W-1:0]       entry_rank,
   output logic                   found,
   output logic [IDX_W-1:0]       match_idx,
   output logic [IDX_W-1:0]       match_rank,
   output logic [VAL_W-1:0]       match_value,
   output logic [IDX_W-1:0]       victim_idx,
   output logic [IDX_W-1:0]       victim_rank,
   output logic [KEY_W-1:0]       victim_key
);

   logic                   found_ff;
   logic                   have_ff;
   logic [IDX_W-1:0]       match_idx_ff;
   logic [IDX_W-1:0]       match_rank_ff;
   logic [VAL_W-1:0]       match_value_ff;
   logic [IDX_W-1:0]       victim_idx_ff;
   logic [IDX_W-1:0]       victim_rank_ff;
   logic [KEY_W-1:0]       victim_key_ff;
   logic [COUNT_WIDTH-1:0] victim_count_ff;
   logic                   is_match;
   logic                   is_better;

   // Compare the entry on the read port against the running best
   assign is_match  = (entry_key == find_key) && !found_ff;
   assign is_better = !have_ff || (entry_count < victim_count_ff) ||
                      ((entry_count == victim_count_ff) && (entry_rank > victim_rank_ff));

   // Track whether a match and a victim candidate have been seen
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         found_ff <= 1'b0;
         have_ff  <= 1'b0;
      end else if (ctrl.step) begin
         if (is_match) begin
            found_ff <= 1'b1;
         end
         if (is_better) begin
            have_ff <= 1'b1;
         end
      end
   end

   // Capture the matching entry and the least used, oldest entry
   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         if (is_match) begin
            match_idx_ff   <= entry_idx;
            match_rank_ff  <= entry_rank;
            match_value_ff <= entry_value;
         end
         if (is_better) begin
            victim_idx_ff   <= entry_idx;
            victim_rank_ff  <= entry_rank;
            victim_key_ff   <= entry_key;
            victim_count_ff <= entry_count;
         end
      end
   end

   assign found       = found_ff;
   assign match_idx   = match_idx_ff;
   assign match_rank  = match_rank_ff;
   assign match_value = match_value_ff;
   assign victim_idx  = victim_idx_ff;
   assign victim_rank = victim_rank_ff;
   assign victim_key  = victim_key_ff;

endmodule
